### rtl/ipv4_fragment_header_gen_macros.svh
// Assertion macros used by the checker file.
`ifndef IPV4_FRAGMENT_HEADER_GEN_MACROS_SVH
`define IPV4_FRAGMENT_HEADER_GEN_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define IFHG_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define IFHG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ifhg_pkg.sv
`timescale 1ns / 1ps
package ifhg_pkg;

  // Fragment payload size in bytes (8..248)
  localparam int FRAG_BYTES = 8;

  localparam int HDR_W      = 6;
  localparam int PLEN_W     = 8;
  localparam int SUM_W      = 16;
  localparam int UNITS_W    = 5;
  localparam int TOT_W      = 9;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // More-fragments bit of the flags/offset word
  localparam logic [SUM_W-1:0] MF_BIT = 16'h2000;

endpackage

### rtl/ipv4_fragment_header_gen.sv
`timescale 1ns / 1ps
// Channel   Dir  Signals                      Item
// s_*       in   tvalid tready tdata[31:0]    one packet description
// m_*       out  tvalid tready tdata[47:0]    one fragment header plan
//                tlast
// cfg_*     in   we wdata[0]                  fragment_enable
//
// Each plan makes five passes through the one 18-bit adder (total length,
// two sum adds, two folds), then waits in the output state until m_tready,
// then makes two passes to step the remaining and offset counters; the last
// plan skips those two and the sequencer returns to idle.
// The input is taken only when idle; an empty fragmented payload ends there.
// rst is synchronous and clears the sequencer and fragment_enable.
module ipv4_fragment_header_gen (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [5:0] header_len_bytes, [13:6] payload_len, [29:14] header_partial_sum
  input  logic [ifhg_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [4:0] offset_units, [5] more_fragments, [14:6] total_length,
  // [30:15] header_checksum, [38:31] slice_offset, [46:39] slice_len
  output logic [ifhg_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tlast
);
  import ifhg_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LEN   = 4'd1;
  localparam logic [3:0] ST_ADD1  = 4'd2;
  localparam logic [3:0] ST_ADD2  = 4'd3;
  localparam logic [3:0] ST_FOLD1 = 4'd4;
  localparam logic [3:0] ST_FOLD2 = 4'd5;
  localparam logic [3:0] ST_OUT   = 4'd6;
  localparam logic [3:0] ST_REM   = 4'd7;
  localparam logic [3:0] ST_OFF   = 4'd8;

  localparam logic [PLEN_W-1:0] FRAG_B8  = PLEN_W'(FRAG_BYTES);
  localparam logic [PLEN_W-1:0] FRAG_NEG = PLEN_W'(256 - FRAG_BYTES);

  logic [3:0]        state;
  logic              frag_en;
  logic [HDR_W-1:0]  hdr;
  logic [SUM_W-1:0]  psum;
  logic [PLEN_W-1:0] rem;
  logic [PLEN_W-1:0] off;
  logic [TOT_W-1:0]  tot;
  logic [17:0]       acc;
  logic              more;
  logic [PLEN_W-1:0] len;

  logic [UNITS_W-1:0] out_units;
  logic               out_more;
  logic [TOT_W-1:0]   out_tot;
  logic [SUM_W-1:0]   out_csum;
  logic [PLEN_W-1:0]  out_off;
  logic [PLEN_W-1:0]  out_len;

  logic              more_cur;
  logic [PLEN_W-1:0] len_cur;
  logic [SUM_W-1:0]  fragword;
  logic [17:0]       op_a;
  logic [17:0]       op_b;
  logic [17:0]       sum;

  // Slice of the current fragment
  assign more_cur = frag_en && (rem > FRAG_B8);
  assign len_cur  = more_cur ? FRAG_B8 : rem;
  assign fragword = {8'd0, 3'd0, off[7:3]} | (more ? MF_BIT : '0);

  // Shared adder operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_LEN: begin
        op_a = {12'd0, hdr};
        op_b = {10'd0, len_cur};
      end
      ST_ADD1: begin
        op_a = {2'd0, psum};
        op_b = {9'd0, tot};
      end
      ST_ADD2: begin
        op_a = acc;
        op_b = {2'd0, fragword};
      end
      ST_FOLD1, ST_FOLD2: begin
        op_a = {2'd0, acc[15:0]};
        op_b = {16'd0, acc[17:16]};
      end
      ST_REM: begin
        op_a = {10'd0, rem};
        op_b = {10'd0, FRAG_NEG};
      end
      ST_OFF: begin
        op_a = {10'd0, off};
        op_b = {10'd0, FRAG_B8};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign sum = op_a + op_b;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frag_en <= 1'b0;
    end else if (cfg_we) begin
      frag_en <= cfg_wdata;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (frag_en && (s_tdata[13:6] == '0)) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_LEN;
            end
          end
        end
        ST_LEN:   state <= ST_ADD1;
        ST_ADD1:  state <= ST_ADD2;
        ST_ADD2:  state <= ST_FOLD1;
        ST_FOLD1: state <= ST_FOLD2;
        ST_FOLD2: state <= ST_OUT;
        ST_OUT: begin
          if (m_tready) begin
            state <= out_more ? ST_REM : ST_IDLE;
          end
        end
        ST_REM:   state <= ST_OFF;
        ST_OFF:   state <= ST_LEN;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        hdr  <= s_tdata[5:0];
        rem  <= s_tdata[13:6];
        psum <= s_tdata[29:14];
        off  <= '0;
      end
      ST_LEN: begin
        tot  <= sum[TOT_W-1:0];
        more <= more_cur;
        len  <= len_cur;
      end
      ST_ADD1, ST_ADD2, ST_FOLD1: begin
        acc <= sum;
      end
      ST_FOLD2: begin
        out_units <= off[7:3];
        out_more  <= more;
        out_tot   <= tot;
        out_csum  <= ~sum[15:0];
        out_off   <= off;
        out_len   <= len;
      end
      ST_REM: begin
        rem <= sum[PLEN_W-1:0];
      end
      ST_OFF: begin
        off <= sum[PLEN_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tlast  = !out_more;
  assign m_tdata  = {1'b0, out_len, out_off, out_csum, out_tot, out_more, out_units};

endmodule

### rtl/ifhg_checker.sv
`timescale 1ns / 1ps
`include "ipv4_fragment_header_gen_macros.svh"
module ifhg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ifhg_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast
);

  // Hold a stalled plan
  `IFHG_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "plan not held")

  // Never take a packet while a plan is pending
  `IFHG_ASSERT(a_excl, !(s_tready && m_tvalid), "input ready while output valid")

  // Last mark and more-fragments flag agree
  `IFHG_ASSERT(a_mf, !m_tvalid || (m_tlast == !m_tdata[5]), "tlast disagrees with MF")

  // Stay busy between fragments of one packet
  `IFHG_ASSERT_NEXT(a_busy, m_tvalid && m_tready && !m_tlast, !s_tready && !m_tvalid, "gap expected")

  // Return to idle after the last fragment
  `IFHG_ASSERT_NEXT(a_done, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid, "not idle")

endmodule

bind ipv4_fragment_header_gen ifhg_checker u_ifhg_checker (.*);
